// ===== hw/rtl/utp_pkg.sv =====
package utp_pkg;

   // Character codes of the text forms
   localparam logic [7:0] CHAR_DASH   = 8'h2D;
   localparam logic [7:0] CHAR_LBRACE = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE = 8'h7D;

   // Form codes on the result port
   localparam logic [1:0] FORM_BARE   = 2'd0;
   localparam logic [1:0] FORM_HYPHEN = 2'd1;
   localparam logic [1:0] FORM_BRACED = 2'd2;

   // Position counter: saturates one past the longest form
   localparam int unsigned POS_W = 6;
   localparam logic [POS_W-1:0] POS_SAT = 6'd39;

   // Form lengths
   localparam logic [POS_W-1:0] LEN_BARE   = 6'd32;
   localparam logic [POS_W-1:0] LEN_HYPHEN = 6'd36;
   localparam logic [POS_W-1:0] LEN_BRACED = 6'd38;

   // Position of the final character of each form
   localparam logic [POS_W-1:0] END_BARE   = 6'd31;
   localparam logic [POS_W-1:0] END_HYPHEN = 6'd35;
   localparam logic [POS_W-1:0] END_BRACED = 6'd37;

   localparam int unsigned UUID_W = 128;

   // Per-character checks against the current position
   typedef struct packed {
      logic       hex;
      logic [3:0] nibble;
      logic       bare_ok;
      logic       hyphen_ok;
      logic       braced_ok;
   } char_chk_type;

   // One result word
   typedef struct packed {
      logic        valid_res;
      logic [1:0]  form;
      logic [63:0] uuid_upper;
      logic [63:0] uuid_lower;
   } result_type;

endpackage

// ===== hw/rtl/uuid_text_parser.sv =====
// UUID text parser. Takes the text of a UUID one character per word and, on
// the word marked last (or on an empty-string word), returns one result word:
// a valid flag, the form (bare 32 digits, hyphenated 36, braced 38) and the
// 128-bit value split into upper and lower halves, all zero when the text is
// not an accepted form. Hex digits may be upper or lower case. A character
// word is taken every cycle unless an ending word is held back; each word
// passes an input register and then decode and state update, and a result
// word is loaded into the output register as its final character leaves the
// input register. Words go on being taken while a result waits in the output
// register; only a full one that is not being drained holds back an ending word.
module uuid_text_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_last,
   input  logic        req_empty_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_valid_res,
   output logic [1:0]  rsp_form,
   output logic [63:0] rsp_uuid_upper,
   output logic [63:0] rsp_uuid_lower
);

   logic                s1_valid_ff, s1_valid_in;
   logic [7:0]          s1_char_ff;
   logic                s1_last_ff;
   logic                s1_empty_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   utp_pkg::result_type rsp_ff;
   utp_pkg::result_type result;
   logic                s1_ends;
   logic                out_free;
   logic                s1_go;
   logic                take;

   // Advance the held word unless its result has nowhere to go
   always_comb begin
      s1_ends     = s1_last_ff | s1_empty_ff;
      out_free    = !rsp_valid_ff || rsp_ready;
      s1_go       = s1_valid_ff && (!s1_ends || out_free);
      req_ready   = !s1_valid_ff || s1_go;
      take        = req_valid && req_ready;
      s1_valid_in = take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   end

   // Hold the incoming word
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (take) begin
         s1_char_ff  <= req_char_code;
         s1_last_ff  <= req_last;
         s1_empty_ff <= req_empty_string;
      end
   end

   utp_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .advance      (s1_go),
      .char_code    (s1_char_ff),
      .last         (s1_last_ff),
      .empty_string (s1_empty_ff),
      .result       (result)
   );

   // Load a result word, drop it once taken
   always_comb begin
      if (s1_go && s1_ends) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_go && s1_ends) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_valid_res  = rsp_ff.valid_res;
   assign rsp_form       = rsp_ff.form;
   assign rsp_uuid_upper = rsp_ff.uuid_upper;
   assign rsp_uuid_lower = rsp_ff.uuid_lower;

   // An invalid string carries an all-zero result
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |->
         (rsp_form == utp_pkg::FORM_BARE && rsp_uuid_upper == 64'd0 &&
          rsp_uuid_lower == 64'd0))
      else $error("invalid result word carries nonzero fields");

   // A valid result names one of the three forms
   a_form_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |->
         (rsp_form == utp_pkg::FORM_BARE || rsp_form == utp_pkg::FORM_HYPHEN ||
          rsp_form == utp_pkg::FORM_BRACED))
      else $error("valid result word with unknown form");

   // An ending word that advances shows up as a result next cycle
   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_ends) |=> rsp_valid)
      else $error("ending word produced no result word");

   // Input stalls only while an ending word is held and its result is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_ends && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked result");

endmodule

// ===== hw/rtl/utp_char_decode.sv =====
module utp_char_decode (
   input  logic [7:0]                  char_code,
   input  logic [utp_pkg::POS_W-1:0]   pos,
   output utp_pkg::char_chk_type       chk
);

   logic       hex;
   logic [3:0] nibble;
   logic       dash_slot;
   logic       braced_dash_slot;

   // Map the character to a hex nibble
   always_comb begin
      hex    = 1'b1;
      nibble = 4'd0;
      case (char_code) inside
         [8'h30:8'h39]: nibble = 4'(char_code - 8'h30);
         [8'h61:8'h66]: nibble = 4'(char_code - 8'h61 + 8'd10);
         [8'h41:8'h46]: nibble = 4'(char_code - 8'h41 + 8'd10);
         default: begin
            hex    = 1'b0;
            nibble = 4'd0;
         end
      endcase
   end

   // Hyphen positions of the hyphenated form, and shifted by one for braces
   always_comb begin
      dash_slot        = pos inside {6'd8, 6'd13, 6'd18, 6'd23};
      braced_dash_slot = pos inside {6'd9, 6'd14, 6'd19, 6'd24};
   end

   // Check the character against each form at this position
   always_comb begin
      chk.hex     = hex;
      chk.nibble  = nibble;
      chk.bare_ok = (pos < utp_pkg::LEN_BARE) && hex;
      chk.hyphen_ok = (pos < utp_pkg::LEN_HYPHEN) &&
                      (dash_slot ? (char_code == utp_pkg::CHAR_DASH) : hex);
      if (pos >= utp_pkg::LEN_BRACED) begin
         chk.braced_ok = 1'b0;
      end else if (pos == '0) begin
         chk.braced_ok = (char_code == utp_pkg::CHAR_LBRACE);
      end else if (pos == utp_pkg::END_BRACED) begin
         chk.braced_ok = (char_code == utp_pkg::CHAR_RBRACE);
      end else if (braced_dash_slot) begin
         chk.braced_ok = (char_code == utp_pkg::CHAR_DASH);
      end else begin
         chk.braced_ok = hex;
      end
   end

endmodule

// ===== hw/rtl/utp_accum.sv =====
module utp_accum (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [7:0]            char_code,
   input  logic                  last,
   input  logic                  empty_string,
   output utp_pkg::result_type   result
);

   logic [utp_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [utp_pkg::UUID_W-1:0] acc_ff, acc_in;
   logic                       bare_ff, bare_in;
   logic                       hyphen_ff, hyphen_in;
   logic                       braced_ff, braced_in;

   utp_pkg::char_chk_type      chk;
   logic [utp_pkg::UUID_W-1:0] acc_upd;
   logic                       bare_upd, hyphen_upd, braced_upd;
   logic                       ends;

   utp_char_decode u_decode (
      .char_code (char_code),
      .pos       (pos_ff),
      .chk       (chk)
   );

   // Fold the current character into the string state
   always_comb begin
      acc_upd    = chk.hex ? {acc_ff[utp_pkg::UUID_W-5:0], chk.nibble} : acc_ff;
      bare_upd   = bare_ff & chk.bare_ok;
      hyphen_upd = hyphen_ff & chk.hyphen_ok;
      braced_upd = braced_ff & chk.braced_ok;
      ends       = last | empty_string;
   end

   // Pick the form that the completed string matches
   always_comb begin
      result = '0;
      if (!empty_string) begin
         if (pos_ff == utp_pkg::END_BARE && bare_upd) begin
            result.valid_res = 1'b1;
            result.form      = utp_pkg::FORM_BARE;
         end else if (pos_ff == utp_pkg::END_HYPHEN && hyphen_upd) begin
            result.valid_res = 1'b1;
            result.form      = utp_pkg::FORM_HYPHEN;
         end else if (pos_ff == utp_pkg::END_BRACED && braced_upd) begin
            result.valid_res = 1'b1;
            result.form      = utp_pkg::FORM_BRACED;
         end
      end
      if (result.valid_res) begin
         result.uuid_upper = acc_upd[127:64];
         result.uuid_lower = acc_upd[63:0];
      end
   end

   // Next state: clear at the end of a string, else advance
   always_comb begin
      pos_in    = pos_ff;
      acc_in    = acc_ff;
      bare_in   = bare_ff;
      hyphen_in = hyphen_ff;
      braced_in = braced_ff;
      if (advance) begin
         if (ends) begin
            pos_in    = '0;
            acc_in    = '0;
            bare_in   = 1'b1;
            hyphen_in = 1'b1;
            braced_in = 1'b1;
         end else begin
            pos_in    = (pos_ff < utp_pkg::POS_SAT) ? pos_ff + 1'b1 : pos_ff;
            acc_in    = acc_upd;
            bare_in   = bare_upd;
            hyphen_in = hyphen_upd;
            braced_in = braced_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         acc_ff    <= '0;
         bare_ff   <= 1'b1;
         hyphen_ff <= 1'b1;
         braced_ff <= 1'b1;
      end else begin
         pos_ff    <= pos_in;
         acc_ff    <= acc_in;
         bare_ff   <= bare_in;
         hyphen_ff <= hyphen_in;
         braced_ff <= braced_in;
      end
   end

endmodule
